>>> rtl/core/ecpg_pkg.sv
`timescale 1ns / 1ps

package ecpg_pkg;

	// Width of every point coordinate on the result side (two's complement wrap).
	localparam int OUT_BITS = 12;

	// Width of the semi-axis register and its reset value.
	localparam int CFG_BITS = 8;
	localparam logic [CFG_BITS-1:0] AXIS_RESET = 8'd90;

	// Control that travels with each beat down the pipeline.
	typedef struct packed {
		logic vld;  // beat present in this stage
		logic ok;   // offset lies inside the semi-axis and the semi-axis is nonzero
	} ctl_t;

endpackage

>>> rtl/core/ellipse_column_point_generator.sv
`timescale 1ns / 1ps

// Channel    | Handshake          | Payload
// -----------+--------------------+----------------------------------------------------
// command    | start / busy       | center_x, center_y, column_offset, column_limit,
//            |                    | minor_semi_axis
// result     | done (strobe)      | height, x_right, x_left, y_below, y_above,
//            |                    | valid_res, in_span
// config     | cfg_we             | cfg_wdata (horizontal semi-axis a)
//
// A beat is taken on every edge with start high; busy stays low, so one column enters
// per clock. Each result passes through these registers in order:
// stage 1 forms the squares, stage 2 the right-hand side, then one two-stage step per
// bit of the height search (square, then scale and compare), then the output register.
// Reset clears the valid bits of every stage and loads a = 90; payload is not reset.
// The receiver cannot stall, so the pipeline never holds: done pulses for one cycle.
module ellipse_column_point_generator #(
	parameter int COORD_BITS = 10,
	parameter int AXIS_BITS  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [ecpg_pkg::CFG_BITS-1:0]        cfg_wdata,
	// command
	input  logic                                 start,
	output logic                                 busy,
	input  logic [COORD_BITS-1:0]                center_x,
	input  logic [COORD_BITS-1:0]                center_y,
	input  logic [AXIS_BITS-1:0]                 column_offset,
	input  logic [AXIS_BITS-1:0]                 column_limit,
	input  logic [AXIS_BITS-1:0]                 minor_semi_axis,
	// result
	output logic                                 done,
	output logic [AXIS_BITS-1:0]                 height,
	output logic signed [ecpg_pkg::OUT_BITS-1:0] x_right,
	output logic signed [ecpg_pkg::OUT_BITS-1:0] x_left,
	output logic signed [ecpg_pkg::OUT_BITS-1:0] y_below,
	output logic signed [ecpg_pkg::OUT_BITS-1:0] y_above,
	output logic                                 valid_res,
	output logic                                 in_span
);

	localparam int W     = AXIS_BITS;
	localparam int OB    = ecpg_pkg::OUT_BITS;
	localparam int RHS_W = 4 * W + 2;
	// depth of the sideband delay line: it matches the registers from the first stage register to the last bit step
	localparam int SIDE_DLY = 2 * W + 1;

	// Point data that skips the height search and waits beside it.
	typedef struct packed {
		logic [OB-1:0]         xr;
		logic [OB-1:0]         xl;
		logic [COORD_BITS-1:0] cy;
		logic                  span;
	} side_t;

	logic [ecpg_pkg::CFG_BITS-1:0] axis_q;
	logic [W-1:0]                  a_w;
	logic                          accept;

	// stage 1: squares
	ecpg_pkg::ctl_t ctl_s1;
	side_t          side_s1;
	logic [2*W-1:0] a2_s1, i2_s1, b2_s1;

	// stage 2: right-hand side 4*b^2*(a^2 - i^2)
	ecpg_pkg::ctl_t   ctl_s2;
	logic [RHS_W-1:0] rhs_s2;
	logic [2*W-1:0]   a2_s2;
	logic [2*W-1:0]   diff;

	// sideband delay line
	side_t side_dly_q [SIDE_DLY];

	// chain between bit steps
	ecpg_pkg::ctl_t   ctl_c [W+1];
	logic [W-1:0]     j_c   [W+1];
	logic [RHS_W-1:0] rhs_c [W+1];
	logic [2*W-1:0]   a2_c  [W+1];

	logic [W-1:0] height_d;
	side_t        side_end;

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign a_w    = W'(axis_q);

	// Hold the semi-axis; the user must write it only while no beat is in flight (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= ecpg_pkg::AXIS_RESET;
		end else if (cfg_we) begin
			axis_q <= cfg_wdata;
		end
	end

	// Valid bits of the two front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.vld <= accept;
			ctl_s1.ok  <= (a_w != '0) && (column_offset <= a_w);
			ctl_s2     <= ctl_s1;
		end
	end

	// Form the squares and the x points; the x points need nothing else.
	always_ff @(posedge clk) begin
		a2_s1        <= (2*W)'(a_w) * (2*W)'(a_w);
		i2_s1        <= (2*W)'(column_offset) * (2*W)'(column_offset);
		b2_s1        <= (2*W)'(minor_semi_axis) * (2*W)'(minor_semi_axis);
		side_s1.xr   <= OB'(center_x) + OB'(column_offset);
		side_s1.xl   <= OB'(center_x) - OB'(column_offset);
		side_s1.cy   <= center_y;
		side_s1.span <= (column_offset <= column_limit);
	end

	// Drop the difference to zero outside the ellipse so nothing wraps; the height
	// gets forced to zero at the end anyway.
	assign diff = ctl_s1.ok ? (a2_s1 - i2_s1) : '0;

	always_ff @(posedge clk) begin
		rhs_s2 <= (RHS_W'(b2_s1) * RHS_W'(diff)) << 2;
		a2_s2  <= a2_s1;
	end

	// Advance the sideband alongside the search.
	always_ff @(posedge clk) begin
		side_dly_q[0] <= side_s1;
		for (int k = 1; k < SIDE_DLY; k++) begin
			side_dly_q[k] <= side_dly_q[k-1];
		end
	end

	assign side_end = side_dly_q[SIDE_DLY-1];

	// Height search: settle one bit per two-stage step, most significant first.
	assign ctl_c[0] = ctl_s2;
	assign j_c[0]   = '0;
	assign rhs_c[0] = rhs_s2;
	assign a2_c[0]  = a2_s2;

	for (genvar g = 0; g < W; g++) begin : g_bit
		ecpg_bit_stage #(
			.W   (W),
			.BIT (W - 1 - g)
		) u_bit (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[g]),
			.j_in    (j_c[g]),
			.rhs_in  (rhs_c[g]),
			.a2_in   (a2_c[g]),
			.ctl_out (ctl_c[g+1]),
			.j_out   (j_c[g+1]),
			.rhs_out (rhs_c[g+1]),
			.a2_out  (a2_c[g+1])
		);
	end

	// With a = 0 every candidate passes the compare, so gate on the range flag.
	assign height_d = ctl_c[W].ok ? j_c[W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_c[W].vld;
		end
	end

	always_ff @(posedge clk) begin
		height    <= height_d;
		x_right   <= side_end.xr;
		x_left    <= side_end.xl;
		y_below   <= OB'(side_end.cy) + OB'(height_d);
		y_above   <= OB'(side_end.cy) - OB'(height_d);
		valid_res <= ctl_c[W].ok;
		in_span   <= side_end.span;
	end

`ifndef SYNTHESIS
	logic [OB-1:0] x_gap, y_gap;
	assign x_gap = OB'(x_right - x_left);
	assign y_gap = OB'(y_below - y_above);

	a_zero_height_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (height == '0))
		else $error("height nonzero outside the semi-axis");

	a_flat_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |-> (y_above == y_below))
		else $error("y points differ outside the semi-axis");

	a_y_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (y_gap == OB'({height, 1'b0})))
		else $error("y points not mirrored about the center");

	a_x_span: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_res) |-> (x_gap[0] == 1'b0 &&
			x_gap <= OB'(2 * ((1 << ecpg_pkg::CFG_BITS) - 1))))
		else $error("x points wider than the semi-axis allows");
`endif

endmodule

>>> rtl/core/ecpg_bit_stage.sv
`timescale 1ns / 1ps

// One bit of the half-height search, two register stages deep.
// Stage 1 squares the odd candidate t = 2*cand - 1, stage 2 scales the square by a^2
// and keeps the candidate bit when t^2 * a^2 <= rhs.
module ecpg_bit_stage #(
	parameter int W   = 8,
	parameter int BIT = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ecpg_pkg::ctl_t        ctl_in,
	input  logic [W-1:0]          j_in,
	input  logic [4*W+1:0]        rhs_in,
	input  logic [2*W-1:0]        a2_in,
	output ecpg_pkg::ctl_t        ctl_out,
	output logic [W-1:0]          j_out,
	output logic [4*W+1:0]        rhs_out,
	output logic [2*W-1:0]        a2_out
);

	localparam int SQ_W  = 2 * W + 2;
	localparam int RHS_W = 4 * W + 2;

	logic [W-1:0]   cand;
	logic [W:0]     odd_t;
	logic [RHS_W-1:0] prod;

	ecpg_pkg::ctl_t   ctl_s1, ctl_s2;
	logic [W-1:0]     j_s1, j_s2;
	logic [SQ_W-1:0]  sq_s1;
	logic [RHS_W-1:0] rhs_s1, rhs_s2;
	logic [2*W-1:0]   a2_s1, a2_s2;

	assign cand  = j_in | (W'(1) << BIT);
	assign odd_t = {cand, 1'b0} - (W+1)'(1);
	assign prod  = RHS_W'(sq_s1) * RHS_W'(a2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		j_s1   <= j_in;
		sq_s1  <= SQ_W'(odd_t) * SQ_W'(odd_t);
		rhs_s1 <= rhs_in;
		a2_s1  <= a2_in;

		// keep the bit when the candidate still fits under the ellipse
		if (prod <= rhs_s1) begin
			j_s2 <= j_s1 | (W'(1) << BIT);
		end else begin
			j_s2 <= j_s1;
		end
		rhs_s2 <= rhs_s1;
		a2_s2  <= a2_s1;
	end

	assign ctl_out = ctl_s2;
	assign j_out   = j_s2;
	assign rhs_out = rhs_s2;
	assign a2_out  = a2_s2;

endmodule
